FILE: rtl/gutf_pkg.sv
// Shared types, constants and the Greek letter name table.
`default_nettype none

package gutf_pkg;

  // UTF-8 lead bytes of the Greek block
  localparam logic [7:0] LEAD_CE_BYTE = 8'hCE;
  localparam logic [7:0] LEAD_CF_BYTE = 8'hCF;

  // Longest letter name in bytes, and the width of a name buffer
  localparam int unsigned NAME_BYTES = 7;
  localparam int unsigned NAME_W     = 8 * NAME_BYTES;

  // Byte count of one expansion, up to NAME_BYTES
  typedef logic [2:0] len_t;

  // Lead byte held between items
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_CE   = 2'd1,
    HELD_CF   = 2'd2
  } held_t;

  // What the back end emits for one item
  typedef enum logic [1:0] {
    JOB_BYTE = 2'd0,  // one byte: pass-through, or a flushed lead
    JOB_PAIR = 2'd1,  // held lead byte, then the data byte
    JOB_NAME = 2'd2   // letter name looked up from lead and data byte
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        lead_cf;
    logic [7:0]  data;
  } job_t;

  // Letter name for a lead and a second byte, right-aligned, zero when unmatched
  function automatic logic [NAME_W-1:0] name_text(input logic lead_cf,
                                                  input logic [7:0] b);
    logic [NAME_W-1:0] t;
    t = '0;
    if (lead_cf) begin
      unique case (b)
        8'h80: t = "pi";
        8'h81: t = "rho";
        8'h82: t = "sigma";
        8'h83: t = "sigma";
        8'h84: t = "tau";
        8'h85: t = "upsilon";
        8'h86: t = "phi";
        8'h87: t = "chi";
        8'h88: t = "psi";
        8'h89: t = "omega";
        8'h90: t = "beta";
        8'h91: t = "theta";
        8'h95: t = "phi";
        8'h96: t = "pi";
        8'h97: t = "kai";
        default: t = '0;
      endcase
    end else begin
      unique case (b)
        8'h91: t = "Alpha";
        8'h92: t = "Beta";
        8'h93: t = "Gamma";
        8'h94: t = "Delta";
        8'h95: t = "Epsilon";
        8'h96: t = "Zeta";
        8'h97: t = "Eta";
        8'h98: t = "Theta";
        8'h99: t = "Iota";
        8'h9A: t = "Kappa";
        8'h9B: t = "Lambda";
        8'h9C: t = "Mu";
        8'h9D: t = "Nu";
        8'h9E: t = "Xi";
        8'h9F: t = "Omicron";
        8'hA0: t = "Pi";
        8'hA1: t = "Rho";
        8'hA3: t = "Sigma";
        8'hA4: t = "Tau";
        8'hA5: t = "Upsilon";
        8'hA6: t = "Phi";
        8'hA7: t = "Chi";
        8'hA8: t = "Psi";
        8'hA9: t = "Omega";
        8'hB1: t = "alpha";
        8'hB2: t = "beta";
        8'hB3: t = "gamma";
        8'hB4: t = "delta";
        8'hB5: t = "epsilon";
        8'hB6: t = "zeta";
        8'hB7: t = "eta";
        8'hB8: t = "theta";
        8'hB9: t = "iota";
        8'hBA: t = "kappa";
        8'hBB: t = "lambda";
        8'hBC: t = "mu";
        8'hBD: t = "nu";
        8'hBE: t = "xi";
        8'hBF: t = "omicron";
        default: t = '0;
      endcase
    end
    return t;
  endfunction

  // Length of a right-aligned name: highest nonzero byte position plus one
  function automatic len_t name_len(input logic [NAME_W-1:0] t);
    len_t n;
    n = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (t[8*i +: 8] != 8'h00) n = len_t'(i + 1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gutf_front.sv
// Front end: accepts input items, tracks the held lead byte, issues jobs.
`default_nettype none

module gutf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // [7:0] data_byte
  input  wire logic          s_tuser,   // [0] mode
  input  wire logic          full,
  output logic               push,
  output gutf_pkg::job_t     job
);
  import gutf_pkg::*;

  held_t             held;
  held_t             held_next;
  logic              accept;
  logic              lead_cf;
  logic [NAME_W-1:0] text;

  // Take an item whenever the queue has room
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign lead_cf  = (held == HELD_CF);
  assign text     = name_text(lead_cf, s_tdata);

  // Classify the item against the held lead
  always_comb begin
    held_next    = held;
    push         = 1'b0;
    job.kind     = JOB_BYTE;
    job.lead_cf  = lead_cf;
    job.data     = s_tdata;
    if (accept) begin
      held_next = HELD_NONE;
      if (s_tuser) begin
        // end of stream: flush a held lead on its own
        if (held == HELD_CE || held == HELD_CF) begin
          push     = 1'b1;
          job.kind = JOB_BYTE;
          job.data = lead_cf ? LEAD_CF_BYTE : LEAD_CE_BYTE;
        end
      end else if (held == HELD_CE || held == HELD_CF) begin
        push     = 1'b1;
        job.kind = (name_len(text) != '0) ? JOB_NAME : JOB_PAIR;
      end else if (s_tdata == LEAD_CE_BYTE) begin
        held_next = HELD_CE;
      end else if (s_tdata == LEAD_CF_BYTE) begin
        held_next = HELD_CF;
      end else begin
        push = 1'b1;
      end
    end
  end

  // Hold lead state
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= HELD_NONE;
    end else begin
      held <= held_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gutf_queue.sv
// Job queue between the front end and the back end.
`default_nettype none

module gutf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire gutf_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output gutf_pkg::job_t      head,
  output logic                empty
);
  import gutf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count_next;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    count_next = count + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(DEPTH))
    else $error("queue fill level out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/gutf_back.sv
// Back end: expands queued jobs into output bytes, one byte per cycle while m_tready is high.
`default_nettype none

module gutf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gutf_pkg::job_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [7:0]          m_tdata,   // [7:0] out_byte
  output logic                m_tlast
);
  import gutf_pkg::*;

  // Pending bytes, next one in the top byte
  logic [NAME_W-1:0] seq;
  logic [NAME_W-1:0] seq_next;
  len_t              cnt;
  len_t              cnt_next;
  logic              load;
  logic [NAME_W-1:0] text;
  len_t              text_len;
  logic [5:0]        align;

  assign m_tvalid = (cnt != '0);
  assign m_tdata  = seq[NAME_W-1 -: 8];
  assign m_tlast  = (cnt == len_t'(1));

  // Free to take the next job when idle or on the final byte leaving
  assign load = (cnt == '0) || (m_tlast && m_tready);
  assign pop  = load && !empty;

  assign text     = name_text(head.lead_cf, head.data);
  assign text_len = name_len(text);
  assign align    = {3'(len_t'(NAME_BYTES) - text_len), 3'b000};

  // Load a new job or shift out the current one
  always_comb begin
    seq_next = seq;
    cnt_next = cnt;
    if (pop) begin
      unique case (head.kind)
        JOB_NAME: begin
          seq_next = text << align;
          cnt_next = text_len;
        end
        JOB_PAIR: begin
          seq_next = {(head.lead_cf ? LEAD_CF_BYTE : LEAD_CE_BYTE), head.data,
                      (NAME_W - 16)'(0)};
          cnt_next = len_t'(2);
        end
        default: begin
          seq_next = {head.data, (NAME_W - 8)'(0)};
          cnt_next = len_t'(1);
        end
      endcase
    end else if (m_tvalid && m_tready) begin
      seq_next = seq << 8;
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    seq <= seq_next;
  end

`ifndef SYNTHESIS
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tready && m_tlast && !empty) |=> m_tvalid)
    else $error("output gap while jobs are queued");
`endif

endmodule

`default_nettype wire

FILE: rtl/greek_utf8_transliterator.sv
// Top level of the Greek UTF-8 transliterator.
`default_nettype none

// Replaces UTF-8 Greek letters in a byte stream by their Latin names; every
// other byte passes through. A 0xCE/0xCF lead is held silently; the next byte
// either yields the letter name (2 to 7 bytes) or, when unmatched, the lead
// byte followed by that byte. An end-of-stream item (s_tuser = 1) flushes a
// held lead alone. m_tlast marks the final byte caused by each input item.
// Input items are taken one per cycle while the job queue (QUEUE_DEPTH
// entries) has room; the output side emits one byte per cycle while m_tready
// is high, so the sustained input rate is set by the total output byte count.
// An accepted item is registered in the job queue and then in the back end's
// shift register before its first byte appears on the output.
module greek_utf8_transliterator #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tuser,   // [0] mode
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast    // last_of_run
);
  import gutf_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head;

  // Classify input items
  gutf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .full     (full),
    .push     (push),
    .job      (push_job)
  );

  // Buffer jobs between the two sides
  gutf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // Expand jobs into output bytes
  gutf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

FILE: tb/tb_greek_utf8_transliterator.sv
// Self-checking testbench for the Greek UTF-8 transliterator: directed rows, then random text.
`default_nettype none

module tb_greek_utf8_transliterator;
  import gutf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 145;
  localparam int TYPED_NONE    = -1;   // row checked against the predictor only

  // One output byte as the block should produce it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  // One directed row: item fields plus an optional hand-typed result
  typedef struct {
    logic       eos;
    logic [7:0] data;
    int         typed_n;
    logic [7:0] byte0;
    logic [7:0] byte1;
    string      typed_name;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int src_idle_pct  = 21;
  int sink_idle_pct = 53;
  int mismatches    = 0;
  int bytes_checked = 0;
  int items_sent    = 0;
  int names_seen    = 0;
  int cycle_count   = 0;

  held_t      lead_state = HELD_NONE;
  logic [7:0] run_bytes[$];
  text_beat_t expected_text[$];
  text_beat_t want;

  string CAP_NAMES[25] = '{
    "Alpha", "Beta", "Gamma", "Delta", "Epsilon", "Zeta", "Eta", "Theta",
    "Iota", "Kappa", "Lambda", "Mu", "Nu", "Xi", "Omicron", "Pi", "Rho", "",
    "Sigma", "Tau", "Upsilon", "Phi", "Chi", "Psi", "Omega"};
  string SMALL_NAMES[15] = '{
    "alpha", "beta", "gamma", "delta", "epsilon", "zeta", "eta", "theta",
    "iota", "kappa", "lambda", "mu", "nu", "xi", "omicron"};
  string CF_LOW_NAMES[10] = '{
    "pi", "rho", "sigma", "sigma", "tau", "upsilon", "phi", "chi", "psi", "omega"};
  string CF_HIGH_NAMES[8] = '{"beta", "theta", "", "", "", "phi", "pi", "kai"};

  // Directed rows: extremes, each lead outcome, flushes and broken pairs
  stim_row_t directed_rows[25] = '{
    '{1'b0, 8'h41, 1, 8'h41, 8'h00, ""},                 // plain ASCII after reset
    '{1'b0, 8'h00, 1, 8'h00, 8'h00, ""},
    '{1'b0, 8'hFF, 1, 8'hFF, 8'h00, ""},
    '{1'b0, 8'h80, TYPED_NONE, 8'h00, 8'h00, ""},        // stray continuation byte
    '{1'b0, LEAD_CE_BYTE, 0, 8'h00, 8'h00, ""},          // lead held, no output
    '{1'b0, 8'h91, 1, 8'h00, 8'h00, "Alpha"},
    '{1'b0, LEAD_CE_BYTE, 0, 8'h00, 8'h00, ""},
    '{1'b0, 8'hA2, 2, LEAD_CE_BYTE, 8'hA2, ""},          // hole in the capitals
    '{1'b0, LEAD_CF_BYTE, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b0, 8'h85, TYPED_NONE, 8'h00, 8'h00, ""},        // longest name
    '{1'b0, LEAD_CF_BYTE, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b0, 8'h97, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b0, LEAD_CE_BYTE, 0, 8'h00, 8'h00, ""},
    '{1'b0, LEAD_CF_BYTE, 2, LEAD_CE_BYTE, LEAD_CF_BYTE, ""},  // lead right after lead
    '{1'b0, LEAD_CF_BYTE, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b1, 8'h00, 1, LEAD_CF_BYTE, 8'h00, ""},          // flush a held lead
    '{1'b1, 8'hFF, 0, 8'h00, 8'h00, ""},                 // flush with nothing held
    '{1'b0, LEAD_CE_BYTE, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b0, 8'hBF, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b0, LEAD_CF_BYTE, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b0, 8'h8A, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b0, LEAD_CF_BYTE, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b0, 8'h92, TYPED_NONE, 8'h00, 8'h00, ""},        // hole after 0xCF
    '{1'b0, LEAD_CE_BYTE, TYPED_NONE, 8'h00, 8'h00, ""},
    '{1'b1, LEAD_CE_BYTE, 1, LEAD_CE_BYTE, 8'h00, ""}    // data ignored on flush
  };

  greek_utf8_transliterator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Letter name for a held lead and the byte after it; empty when unmatched
  function automatic string letter_name(input held_t lead, input logic [7:0] b);
    if (lead == HELD_CE) begin
      if (b >= 8'h91 && b <= 8'hA9) return CAP_NAMES[b - 8'h91];
      if (b >= 8'hB1 && b <= 8'hBF) return SMALL_NAMES[b - 8'hB1];
    end else if (lead == HELD_CF) begin
      if (b >= 8'h80 && b <= 8'h89) return CF_LOW_NAMES[b - 8'h80];
      if (b >= 8'h90 && b <= 8'h97) return CF_HIGH_NAMES[b - 8'h90];
    end
    return "";
  endfunction

  // Advance the held lead and collect the bytes one item yields
  function automatic void transliterate(input logic eos, input logic [7:0] b);
    held_t      prior;
    logic [7:0] prior_byte;
    string      nm;
    prior      = lead_state;
    prior_byte = (prior == HELD_CF) ? LEAD_CF_BYTE : LEAD_CE_BYTE;
    run_bytes  = {};
    lead_state = HELD_NONE;
    if (eos) begin
      if (prior != HELD_NONE) run_bytes.push_back(prior_byte);
    end else if (prior == HELD_NONE) begin
      if (b == LEAD_CE_BYTE) lead_state = HELD_CE;
      else if (b == LEAD_CF_BYTE) lead_state = HELD_CF;
      else run_bytes.push_back(b);
    end else begin
      nm = letter_name(prior, b);
      if (nm.len() > 0) begin
        for (int k = 0; k < nm.len(); k++) run_bytes.push_back(nm[k]);
        names_seen++;
      end else begin
        run_bytes.push_back(prior_byte);
        run_bytes.push_back(b);
      end
    end
  endfunction

  // Queue the collected bytes, marking the final one
  function automatic void queue_run();
    foreach (run_bytes[k])
      expected_text.push_back(text_beat_t'{run_bytes[k], k == run_bytes.size() - 1});
  endfunction

  // Present one item, with random gaps, and hold it until taken
  task automatic send_item(input logic eos, input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= eos;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic apply_item(input logic eos, input logic [7:0] b);
    send_item(eos, b);
    transliterate(eos, b);
    queue_run();
  endtask

  function automatic logic [7:0] pick_lead();
    return $urandom_range(0, 1) ? LEAD_CF_BYTE : LEAD_CE_BYTE;
  endfunction

  // Stall the output side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Check each output byte against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b", $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = expected_text.pop_front();
        if (want.data !== m_tdata || want.last !== m_tlast) begin
          $display("%0t: expected %02h last %0b, got %02h last %0b",
                   $time, want.data, want.last, m_tdata, m_tlast);
          mismatches++;
        end
        bytes_checked++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, expected_text.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int random_sent;
    int sel;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; typed results replace the predicted ones
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].eos, directed_rows[i].data);
      transliterate(directed_rows[i].eos, directed_rows[i].data);
      if (directed_rows[i].typed_n != TYPED_NONE) begin
        run_bytes = {};
        if (directed_rows[i].typed_name != "") begin
          for (int k = 0; k < directed_rows[i].typed_name.len(); k++)
            run_bytes.push_back(directed_rows[i].typed_name[k]);
        end else begin
          if (directed_rows[i].typed_n > 0) run_bytes.push_back(directed_rows[i].byte0);
          if (directed_rows[i].typed_n > 1) run_bytes.push_back(directed_rows[i].byte1);
        end
      end
      queue_run();
    end

    // Random text: mostly Greek pairs, some plain bytes, flushes and broken pairs
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= 115) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (random_sent >= 55) begin
        src_idle_pct  = 53;
        sink_idle_pct = 21;
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3: begin
          apply_item(1'b0, pick_lead());
          apply_item(1'b0, 8'($urandom_range(8'h80, 8'hBF)));
          random_sent += 2;
        end
        4: begin
          apply_item(1'b0, pick_lead());
          apply_item(1'b0, 8'($urandom));
          random_sent += 2;
        end
        5: begin
          apply_item(1'b0, 8'($urandom_range(8'h20, 8'h7E)));
          random_sent++;
        end
        6: begin
          apply_item(1'b0, 8'($urandom));
          random_sent++;
        end
        7: begin
          apply_item(1'b1, 8'($urandom));
          random_sent++;
        end
        8: begin
          apply_item(1'b0, pick_lead());
          apply_item(1'b1, 8'($urandom));
          random_sent += 2;
        end
        default: begin
          apply_item(1'b0, pick_lead());
          random_sent++;
        end
      endcase
    end
    s_tvalid <= 1'b0;

    // Drain, then watch for stray output
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d letter names); %0d output bytes compared.",
             items_sent, names_seen, bytes_checked);
    $display("Gaps on either side, then none; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/gutf_pkg.sv
rtl/gutf_front.sv
rtl/gutf_queue.sv
rtl/gutf_back.sv
rtl/greek_utf8_transliterator.sv
tb/tb_greek_utf8_transliterator.sv
